// ----- rtl/lifetime_aliasing_heap_allocator_assert.svh -----
// assertion macros used by the port-level checker
// no dependencies
`ifndef LIFETIME_ALIASING_HEAP_ALLOCATOR_ASSERT_SVH
`define LIFETIME_ALIASING_HEAP_ALLOCATOR_ASSERT_SVH
`define LAHA_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define LAHA_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- rtl/laha_pkg.sv -----
// shared types and constants for the heap allocator
// no dependencies
`default_nettype none
package laha_pkg;
   localparam int MAX_HEAPS      = 8;
   localparam int SLOTS_PER_HEAP = 64;
   localparam int ALIGN_BYTES    = 256;
   localparam int HEAP_W         = $clog2(MAX_HEAPS);
   localparam int SLOT_W         = $clog2(SLOTS_PER_HEAP);
   localparam int MEM_W          = HEAP_W + SLOT_W;
   localparam int ALIGN_W        = $clog2(ALIGN_BYTES);
   localparam logic [39:0] M40   = {40{1'b1}};
   localparam logic [47:0] M48   = {48{1'b1}};
   localparam logic OP_BEGIN_FRAME = 1'b0;
   localparam logic OP_ALLOCATE    = 1'b1;
   localparam logic [0:0] REG_HEAP_SIZE = 1'b0;
   localparam logic [0:0] REG_MAX_HEAPS = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [35:0] request_size;
      logic [15:0] first_pass;
      logic [15:0] last_pass;
   } req_type;

   typedef struct packed {
      logic [2:0]  heap_index;
      logic [39:0] offset;
      logic [36:0] aligned_size;
      logic        reused_slot;
      logic        heap_fallback;
      logic        slot_table_full;
      logic [47:0] total_actual;
      logic [47:0] total_saved;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/lifetime_aliasing_heap_allocator.sv -----
// top level of the lifetime-aliased heap allocator
// depends on laha_pkg
//
// usage: raise req_start with req_payload while req_busy is low; the transaction
// is taken at that edge and req_busy stays high until the cycle rsp_valid rises.
// rsp_valid marks rsp_payload for one cycle; the receiver cannot stall.
// sequence: a begin frame sweeps the in-use marks one per cycle, then its result
// shows. an allocate request scans heaps one per cycle (up to 8), then creates a
// heap or falls back if none fits, then scans slots of the chosen heap, each read,
// then compared (up to 64); a reuse hit or a full slot table goes to the result,
// else it reads the last slot, aligns and writes before the result shows.
// the single memory read port and the slot compare unit pace the scan.
// throughput: one transaction at a time; the next is taken at the earliest at
// the edge that ends the result cycle.
// after reset the in-use marks of all 512 slots are cleared before the
// first request is taken; configuration writes are taken at all times.
// csr: heap_size at 0x0, max_heaps at 0x8 (64 bit data).
`default_nettype none
module lifetime_aliasing_heap_allocator import laha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   input  wire req_type     req_payload,
   output logic             req_busy,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_HEAP   = 9'b000000100,
      ST_SREAD  = 9'b000001000,
      ST_SCHK   = 9'b000010000,
      ST_LREAD  = 9'b000100000,
      ST_APPEND = 9'b001000000,
      ST_WRITE  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   localparam int NSLOT = MAX_HEAPS * SLOTS_PER_HEAP;

   state_type state_ff, state_in;
   logic [35:0] heap_size_ff;
   logic [3:0]  max_heaps_ff;
   logic [3:0]  heap_count_ff;
   logic [39:0] heap_cap_ff  [MAX_HEAPS];
   logic [39:0] heap_peak_ff [MAX_HEAPS];
   logic [SLOT_W:0] slot_count_ff [MAX_HEAPS];
   logic [47:0] tot_req_ff, tot_put_ff;
   logic [MEM_W:0] cnt_ff;

   // slot memory: offset, size, first, last
   logic [108:0] slot_mem [NSLOT];
   logic [108:0] rd_ff;
   logic         in_use_mem [NSLOT];
   logic         use_rd_ff;

   req_type     item_ff;
   logic [36:0] asz_ff;
   logic [HEAP_W-1:0] h_ff;
   logic        fb_ff, reused_ff, full_ff;
   logic        frame_ff;
   logic [39:0] off_ff;
   rsp_type     rsp_ff;
   logic        rsp_v_ff;

   logic [3:0] limit;
   assign limit = (max_heaps_ff == 4'd0) ? 4'd1 :
                  (max_heaps_ff > 4'(MAX_HEAPS)) ? 4'(MAX_HEAPS) : max_heaps_ff;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = 64'd0;
      if (csr_paddr[3] == REG_MAX_HEAPS) csr_prdata = {60'd0, max_heaps_ff};
      else csr_prdata = {28'd0, heap_size_ff};
   end

   // address and unpacked read fields
   logic [SLOT_W-1:0] sidx;
   assign sidx = cnt_ff[SLOT_W-1:0];
   logic [MEM_W-1:0] maddr;
   assign maddr = {h_ff, sidx};
   logic [39:0] r_off;
   logic [36:0] r_size;
   logic [15:0] r_first, r_last;
   assign {r_off, r_size, r_first, r_last} = rd_ff;

   logic [HEAP_W-1:0] hscan;
   assign hscan = cnt_ff[HEAP_W-1:0];
   logic [40:0] peak_sum;
   assign peak_sum = {1'b0, heap_peak_ff[hscan]} + {4'd0, asz_ff};

   logic [MEM_W-1:0] prev_addr;
   assign prev_addr = maddr - MEM_W'(1);
   logic [40:0] end_sum;
   assign end_sum = {1'b0, r_off} + {4'd0, r_size} + 41'(ALIGN_BYTES - 1);
   logic [40:0] end_new;
   assign end_new = {1'b0, off_ff} + {4'd0, asz_ff};
   logic [39:0] end_sat;
   assign end_sat = end_new[40] ? M40 : end_new[39:0];

   logic [48:0] put_sum;
   assign put_sum = {1'b0, tot_put_ff} + {12'd0, asz_ff};
   logic [36:0] asz_new;
   logic [36:0] req_ext;
   assign req_ext = {1'b0, req_payload.request_size} + 37'(ALIGN_BYTES - 1);
   assign asz_new = {req_ext[36:ALIGN_W], {ALIGN_W{1'b0}}};

   logic scan_hit;
   assign scan_hit = use_rd_ff && (r_size >= asz_ff) &&
      ((r_last < item_ff.first_pass) || (item_ff.last_pass < r_first));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (cnt_ff == (MEM_W+1)'(NSLOT - 1))
                       state_in = frame_ff ? ST_DONE : ST_IDLE;
         ST_IDLE:   if (req_start) state_in =
                       (req_payload.operation == OP_BEGIN_FRAME) ? ST_CLEAR : ST_HEAP;
         ST_HEAP:   if ((cnt_ff[3:0] < heap_count_ff && !peak_sum[40] &&
                        peak_sum[39:0] <= heap_cap_ff[hscan]) ||
                       cnt_ff[3:0] >= heap_count_ff) state_in = ST_SREAD;
         ST_SREAD:  state_in = ST_SCHK;
         ST_SCHK:   state_in = ST_SREAD;
         ST_LREAD:  state_in = ST_APPEND;
         ST_APPEND: state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_v_ff <= 1'b0;
      if (csr_wr) begin
         if (csr_paddr[3] == REG_HEAP_SIZE) heap_size_ff <= csr_pwdata[35:0];
         else max_heaps_ff <= csr_pwdata[3:0];
      end
      case (state_ff)
         ST_CLEAR: begin
            in_use_mem[cnt_ff[MEM_W-1:0]] <= 1'b0;
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            item_ff <= req_payload;
            asz_ff <= asz_new;
            cnt_ff <= '0;
            fb_ff <= 1'b0;
            reused_ff <= 1'b0;
            full_ff <= 1'b0;
            off_ff <= '0;
            h_ff <= '0;
            frame_ff <= (req_payload.operation == OP_BEGIN_FRAME);
            if (req_start && req_payload.operation == OP_BEGIN_FRAME) begin
               tot_req_ff <= '0;
               tot_put_ff <= '0;
            end else if (req_start) begin
               tot_req_ff <= ({1'b0, tot_req_ff} + {12'd0, asz_new} > {1'b0, M48}) ?
                  M48 : tot_req_ff + {11'd0, asz_new};
            end
         end
         ST_HEAP: begin
            if (cnt_ff[3:0] < heap_count_ff) begin
               if (!peak_sum[40] && peak_sum[39:0] <= heap_cap_ff[hscan]) begin
                  h_ff <= hscan;
                  cnt_ff <= '0;
               end else cnt_ff <= cnt_ff + 1'b1;
            end else begin
               cnt_ff <= '0;
               if (heap_count_ff >= limit) begin
                  h_ff <= '0;
                  fb_ff <= 1'b1;
               end else begin
                  h_ff <= heap_count_ff[HEAP_W-1:0];
                  heap_cap_ff[heap_count_ff[HEAP_W-1:0]] <=
                     ({1'b0, heap_size_ff} > asz_ff) ? {4'd0, heap_size_ff} : {3'd0, asz_ff};
                  heap_peak_ff[heap_count_ff[HEAP_W-1:0]] <= '0;
                  slot_count_ff[heap_count_ff[HEAP_W-1:0]] <= '0;
                  heap_count_ff <= heap_count_ff + 1'b1;
               end
            end
         end
         ST_SREAD: begin
            if (cnt_ff[SLOT_W:0] >= slot_count_ff[h_ff]) begin
               if (slot_count_ff[h_ff] == (SLOT_W+1)'(SLOTS_PER_HEAP)) full_ff <= 1'b1;
               cnt_ff <= {HEAP_W'(0), slot_count_ff[h_ff]};
            end else begin
               rd_ff <= slot_mem[maddr];
               use_rd_ff <= in_use_mem[maddr];
            end
         end
         ST_SCHK: begin
            if (scan_hit) begin
               reused_ff <= 1'b1;
               off_ff <= r_off;
               slot_mem[maddr] <= {r_off, r_size,
                  (item_ff.first_pass < r_first) ? item_ff.first_pass : r_first,
                  (item_ff.last_pass > r_last) ? item_ff.last_pass : r_last};
            end else cnt_ff <= cnt_ff + 1'b1;
         end
         ST_LREAD: rd_ff <= slot_mem[prev_addr];
         ST_APPEND: if (sidx != '0) begin
            off_ff <= end_sum[40] ? M40 : {end_sum[39:ALIGN_W], {ALIGN_W{1'b0}}};
         end
         ST_WRITE: begin
            slot_mem[maddr] <= {off_ff, asz_ff, item_ff.first_pass, item_ff.last_pass};
            in_use_mem[maddr] <= 1'b1;
            slot_count_ff[h_ff] <= slot_count_ff[h_ff] + 1'b1;
            tot_put_ff <= put_sum[48] ? M48 : put_sum[47:0];
            if (end_sat > heap_peak_ff[h_ff]) heap_peak_ff[h_ff] <= end_sat;
         end
         ST_DONE: begin
            rsp_v_ff <= 1'b1;
            if (item_ff.operation == OP_BEGIN_FRAME) rsp_ff <= '0;
            else begin
               rsp_ff.heap_index <= 3'(h_ff);
               rsp_ff.offset <= full_ff ? 40'd0 : off_ff;
               rsp_ff.aligned_size <= asz_ff;
               rsp_ff.reused_slot <= reused_ff;
               rsp_ff.heap_fallback <= fb_ff;
               rsp_ff.slot_table_full <= full_ff;
               rsp_ff.total_actual <= tot_put_ff;
               rsp_ff.total_saved <= (tot_req_ff > tot_put_ff) ? tot_req_ff - tot_put_ff : '0;
            end
         end
         default: ;
      endcase
      if (reset) begin
         cnt_ff <= '0;
         frame_ff <= 1'b0;
         heap_size_ff <= 36'd268435456;
         max_heaps_ff <= 4'd8;
         heap_count_ff <= '0;
         tot_req_ff <= '0;
         tot_put_ff <= '0;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i < MAX_HEAPS; i++) slot_count_ff[i] <= '0;
      end
   end

   // state transitions out of the slot scan are decided here
   state_type nxt;
   always_comb begin
      nxt = state_in;
      if (state_ff == ST_SREAD && cnt_ff[SLOT_W:0] >= slot_count_ff[h_ff])
         nxt = (slot_count_ff[h_ff] == (SLOT_W+1)'(SLOTS_PER_HEAP)) ? ST_DONE : ST_LREAD;
      if (state_ff == ST_SCHK && scan_hit) nxt = ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= nxt;
   end

   assign req_busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/laha_checker.sv -----
// port-level checker for the heap allocator, bound to the top level
// depends on laha_pkg and the assertion macro header
`default_nettype none
`include "lifetime_aliasing_heap_allocator_assert.svh"
module laha_checker import laha_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_start,
   input wire logic    req_busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_payload,
   input wire logic    csr_pready
);
   `LAHA_ASSERT_NEXT(a_take_busy, clock, reset, req_start && !req_busy, req_busy)
   `LAHA_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid, !rsp_valid)
   `LAHA_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, !req_busy)
   `LAHA_ASSERT_IMPL(a_full_off, clock, reset, rsp_valid && rsp_payload.slot_table_full,
      rsp_payload.offset == 40'd0 && !rsp_payload.reused_slot)
   `LAHA_ASSERT_IMPL(a_ready, clock, reset, 1'b1, csr_pready)
endmodule

bind lifetime_aliasing_heap_allocator laha_checker u_laha_checker (.*);
`default_nettype wire

// ----- test/lifetime_aliasing_heap_allocator_checker.sv -----
// watches the request, result and register channels of the heap allocator and predicts each result
// depends on laha_pkg
`default_nettype none
module lifetime_aliasing_heap_allocator_checker import laha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   input  wire logic        req_busy,
   input  wire req_type     req_payload,
   input  wire logic        rsp_valid,
   input  wire rsp_type     rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output int               fail_count,
   output int               pending
);
   localparam int NSLOT = MAX_HEAPS * SLOTS_PER_HEAP;
   localparam int EXP_DEPTH = 8;

   logic [35:0] cfg_heap_size;
   logic [3:0]  cfg_max_heaps;
   int          heaps_made;
   logic [39:0] cap [MAX_HEAPS];
   logic [39:0] peak [MAX_HEAPS];
   int          used_slots [MAX_HEAPS];
   logic [39:0] s_off [NSLOT];
   logic [36:0] s_size [NSLOT];
   logic [15:0] s_first [NSLOT];
   logic [15:0] s_last [NSLOT];
   bit          s_live [NSLOT];
   logic [47:0] bytes_asked;
   logic [47:0] bytes_placed;
   rsp_type     placements [EXP_DEPTH];
   int          wr_idx, rd_idx;

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? M48 : s[47:0];
   endfunction

   function automatic logic [39:0] align40(logic [40:0] v);
      logic [41:0] r;
      r = ({1'b0, v} + 42'(ALIGN_BYTES - 1)) & ~42'(ALIGN_BYTES - 1);
      return r > 42'(M40) ? M40 : r[39:0];
   endfunction

   function automatic rsp_type place(req_type rq);
      rsp_type     r;
      logic [36:0] asz;
      int          h, lim, k, n;
      bit          found, reused;
      logic [40:0] e;
      r = '0;
      if (rq.operation == OP_BEGIN_FRAME) begin
         for (int i = 0; i < NSLOT; i++) s_live[i] = 0;
         bytes_asked = '0;
         bytes_placed = '0;
         return r;
      end
      asz = ({1'b0, rq.request_size} + 37'(ALIGN_BYTES - 1)) & ~37'(ALIGN_BYTES - 1);
      bytes_asked = add_sat48(bytes_asked, 48'(asz));
      found = 0;
      h = 0;
      for (int i = 0; i < heaps_made; i++)
         if (!found && {1'b0, peak[i]} + 41'(asz) <= {1'b0, cap[i]}) begin
            h = i;
            found = 1;
         end
      if (!found) begin
         lim = cfg_max_heaps;
         if (lim < 1) lim = 1;
         if (lim > MAX_HEAPS) lim = MAX_HEAPS;
         if (heaps_made >= lim) begin
            h = 0;
            r.heap_fallback = 1;
         end else begin
            h = heaps_made;
            cap[h] = 40'(cfg_heap_size) > 40'(asz) ? 40'(cfg_heap_size) : 40'(asz);
            peak[h] = '0;
            used_slots[h] = 0;
            heaps_made++;
         end
      end
      reused = 0;
      for (int i = 0; i < used_slots[h]; i++) begin
         k = h * SLOTS_PER_HEAP + i;
         if (!reused && s_live[k] && s_size[k] >= asz &&
             (s_last[k] < rq.first_pass || rq.last_pass < s_first[k])) begin
            if (rq.first_pass < s_first[k]) s_first[k] = rq.first_pass;
            if (rq.last_pass > s_last[k]) s_last[k] = rq.last_pass;
            r.offset = s_off[k];
            reused = 1;
         end
      end
      if (!reused) begin
         n = used_slots[h];
         if (n >= SLOTS_PER_HEAP) r.slot_table_full = 1;
         else begin
            k = h * SLOTS_PER_HEAP + n;
            if (n > 0) r.offset = align40({1'b0, s_off[k-1]} + 41'(s_size[k-1]));
            s_off[k] = r.offset;
            s_size[k] = asz;
            s_first[k] = rq.first_pass;
            s_last[k] = rq.last_pass;
            s_live[k] = 1;
            used_slots[h] = n + 1;
            bytes_placed = add_sat48(bytes_placed, 48'(asz));
            e = {1'b0, r.offset} + 41'(asz);
            if (e > 41'(M40)) e = 41'(M40);
            if (e[39:0] > peak[h]) peak[h] = e[39:0];
         end
      end
      r.heap_index = 3'(h);
      r.aligned_size = asz;
      r.reused_slot = reused;
      r.total_actual = bytes_placed;
      r.total_saved = bytes_asked > bytes_placed ? bytes_asked - bytes_placed : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_heap_size <= 36'd268435456;
         cfg_max_heaps <= 4'd8;
         heaps_made = 0;
         for (int i = 0; i < MAX_HEAPS; i++) used_slots[i] = 0;
         for (int i = 0; i < NSLOT; i++) s_live[i] = 0;
         bytes_asked = '0;
         bytes_placed = '0;
         wr_idx = 0;
         rd_idx = 0;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == REG_HEAP_SIZE) cfg_heap_size <= csr_pwdata[35:0];
            else cfg_max_heaps <= csr_pwdata[3:0];
         end
         // result checked before a same-edge request is predicted
         if (rsp_valid) begin
            if (rd_idx == wr_idx) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = placements[rd_idx % EXP_DEPTH];
               rd_idx++;
               if (want !== rsp_payload) begin
                  if (fail_count < 10) $display("mismatch: expected %p got %p", want, rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_start && !req_busy) begin
            placements[wr_idx % EXP_DEPTH] = place(req_payload);
            wr_idx++;
         end
      end
      pending = wr_idx - rd_idx;
   end
endmodule
`default_nettype wire

// ----- test/tb_lifetime_aliasing_heap_allocator.sv -----
// stimulus and verdict for the heap allocator: directed transactions, then random frames
// depends on laha_pkg, lifetime_aliasing_heap_allocator and its checker
`default_nettype none
module tb_lifetime_aliasing_heap_allocator import laha_pkg::*;;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_start = 0;
   req_type     req_payload = '0;
   logic        req_busy, rsp_valid, csr_pready;
   rsp_type     rsp_payload;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   int          fail_count, pending;
   int          cycles = 0;

   always #5 clock = ~clock;

   lifetime_aliasing_heap_allocator uut (.*);
   lifetime_aliasing_heap_allocator_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 3000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic reg_write(logic [0:0] idx, logic [63:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {idx, 3'b000}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // start stays high after a taken transaction until the next one or a drain
   task automatic send(logic op, logic [35:0] sz, logic [15:0] fp, logic [15:0] lp,
                       bit gaps);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 17) : 0;
      if (wait_n != 0) begin
         req_start <= 0;
         repeat (wait_n) @(posedge clock);
      end
      req_start <= 1;
      req_payload <= '{op, sz, fp, lp};
      do @(posedge clock); while (req_busy);
   endtask

   task automatic drain;
      req_start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [35:0] pick_size;
      case ($urandom_range(0, 9))
         0: return 36'($urandom);
         1: return {4'($urandom), 32'($urandom)};
         2: return 36'($urandom_range(0, 3)) << 8;
         default: return 36'($urandom_range(0, 1 << 20));
      endcase
   endfunction

   initial begin
      logic [15:0] a, b;
      bit          gaps;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, fallback, aliasing
      reg_write(REG_HEAP_SIZE, 64'd256);
      reg_write(REG_MAX_HEAPS, 64'd0);
      send(OP_ALLOCATE, 36'd0, 16'd0, 16'd0, 0);
      send(OP_ALLOCATE, 36'd1, 16'd0, 16'd0, 0);
      send(OP_ALLOCATE, 36'hF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
      send(OP_ALLOCATE, 36'hF_FFFF_FFFF, 16'd0, 16'hFFFF, 0);
      send(OP_BEGIN_FRAME, 36'hF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
      send(OP_ALLOCATE, 36'd256, 16'd1, 16'd2, 0);
      send(OP_ALLOCATE, 36'd200, 16'd3, 16'd4, 0);
      send(OP_ALLOCATE, 36'd257, 16'd2, 16'd3, 0);
      drain();
      reg_write(REG_MAX_HEAPS, 64'd15);
      reg_write(REG_HEAP_SIZE, 64'hF_FFFF_FFFF);
      for (int i = 0; i < 12; i++) send(OP_ALLOCATE, 36'hF_FFFF_FF00, 16'(i), 16'(i), 0);
      send(OP_BEGIN_FRAME, '0, '0, '0, 0);
      drain();
      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         reg_write(REG_MAX_HEAPS, 64'($urandom_range(0, 15)));
         reg_write(REG_HEAP_SIZE, ph == 5 ? 64'd256 : 64'($urandom_range(256, 1 << 24)));
         for (int i = 0; i < 115; i++) begin
            gaps = ($urandom_range(0, 3) != 0);
            a = 16'($urandom_range(0, 40));
            b = a + 16'($urandom_range(0, 6));
            if ($urandom_range(0, 29) == 0) send(OP_BEGIN_FRAME, 36'($urandom), '0, '0, gaps);
            else if ($urandom_range(0, 9) == 0)
               send(OP_ALLOCATE, pick_size(), 16'($urandom), 16'($urandom), gaps);
            else send(OP_ALLOCATE, pick_size(), a, b, gaps);
         end
         drain();
      end
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/laha_pkg.sv
rtl/lifetime_aliasing_heap_allocator.sv
rtl/laha_checker.sv
test/lifetime_aliasing_heap_allocator_checker.sv
test/tb_lifetime_aliasing_heap_allocator.sv
